FILE: src/pas_pkg.sv
`timescale 1ns / 1ps

package pas_pkg;

    // Widths fixed by the item and register formats.
    localparam int ACTION_W    = 32;
    localparam int MODE_W      = 2;
    localparam int PERIOD_W    = 16;
    localparam int LEN_W       = 16;
    localparam int SAMPLE_W    = 32;
    localparam int TIME_W      = 64;
    localparam int BYTES_W     = 64;
    localparam int UPD_PKTS_W  = 32;
    localparam int PKTS_W      = 64;
    localparam int DROPS_W     = 32;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 32;

    // The remainder unit retires this many dividend bits per cycle.
    localparam int DIV_BITS    = 4;
    localparam int DIV_CYCLES  = SAMPLE_W / DIV_BITS;
    localparam int DIV_CNT_W   = $clog2(DIV_CYCLES);

    // Depth of the queue between front and back.
    localparam int FIFO_DEPTH_DEF = 2;

    localparam logic signed [ACTION_W-1:0] DROP_CODE = 32'sd2;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_ACTION = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALT_ACTION     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_MODE    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD  = 8'd3;

    // Sampling modes; the unused code behaves as no sampling.
    localparam logic [MODE_W-1:0] MODE_NONE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RANDOM = 2'd1;
    localparam logic [MODE_W-1:0] MODE_NTH    = 2'd2;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1;

    // A classified item as it travels from front to back.
    typedef struct packed {
        logic                  is_update;
        logic                  sample_en;
        logic [SAMPLE_W-1:0]   sample_val;
        logic [BYTES_W-1:0]    add_bytes;
        logic [UPD_PKTS_W-1:0] add_packets;
        logic [TIME_W-1:0]     use_time;
    } rec_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } back_state_t;

endpackage

FILE: src/pas_front.sv
`timescale 1ns / 1ps

module pas_front
    import pas_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic [MODE_W-1:0]            sample_mode,
    input  logic                         opcode,
    input  logic [LEN_W-1:0]             pkt_len,
    input  logic [SAMPLE_W-1:0]          random_value,
    input  logic [TIME_W-1:0]            time_now,
    input  logic [BYTES_W-1:0]           upd_bytes,
    input  logic [UPD_PKTS_W-1:0]        upd_packets,
    input  logic [TIME_W-1:0]            upd_last_use,
    output rec_t                         rec
);

    logic [SAMPLE_W-1:0] nth_counter_reg;
    logic [SAMPLE_W-1:0] nth_counter_next;
    logic [SAMPLE_W-1:0] counter_inc;

    assign counter_inc = nth_counter_reg + 1'b1;

    // Packets fold into the same add form as updates: one packet, its length,
    // and its time as the new last-use stamp.
    always_comb
    begin
        nth_counter_next = nth_counter_reg;
        rec.is_update    = opcode;
        rec.sample_en    = 1'b0;
        rec.sample_val   = random_value;
        if (opcode)
        begin
            rec.add_bytes   = upd_bytes;
            rec.add_packets = upd_packets;
            rec.use_time    = upd_last_use;
        end
        else
        begin
            rec.add_bytes   = {{(BYTES_W-LEN_W){1'b0}}, pkt_len};
            rec.add_packets = {{(UPD_PKTS_W-1){1'b0}}, 1'b1};
            rec.use_time    = time_now;
            case (sample_mode)
                MODE_RANDOM:
                begin
                    rec.sample_en = 1'b1;
                end
                MODE_NTH:
                begin
                    rec.sample_en  = 1'b1;
                    rec.sample_val = counter_inc;
                    if (accept)
                    begin
                        nth_counter_next = counter_inc;
                    end
                end
                default:
                begin
                    rec.sample_en = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nth_counter_reg <= '0;
        end
        else
        begin
            nth_counter_reg <= nth_counter_next;
        end
    end

endmodule

FILE: src/pas_fifo.sv
`timescale 1ns / 1ps

module pas_fifo
    import pas_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  rec_t wr_data,
    output logic full,
    input  logic rd_en,
    output rec_t rd_data,
    output logic empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    rec_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: src/pas_back.sv
`timescale 1ns / 1ps

module pas_back
    import pas_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic signed [ACTION_W-1:0]  default_action,
    input  logic signed [ACTION_W-1:0]  alt_action,
    input  logic [PERIOD_W-1:0]         sample_period,
    input  logic                        fifo_empty,
    input  rec_t                        fifo_data,
    output logic                        fifo_pop,
    input  logic                        pop,
    output logic                        empty,
    output logic signed [ACTION_W-1:0]  verdict,
    output logic [BYTES_W-1:0]          total_bytes,
    output logic [PKTS_W-1:0]           total_packets,
    output logic [DROPS_W-1:0]          total_drops,
    output logic [TIME_W-1:0]           last_use_time
);

    back_state_t                 state_reg;
    back_state_t                 state_next;
    rec_t                        cur_reg;
    logic [SAMPLE_W-1:0]         dvd_reg;
    logic [PERIOD_W-1:0]         rem_reg;
    logic [PERIOD_W-1:0]         rem_next;
    logic [DIV_CNT_W-1:0]        cnt_reg;
    logic                        out_valid_reg;
    logic signed [ACTION_W-1:0]  verdict_reg;
    logic [BYTES_W-1:0]          bytes_reg;
    logic [PKTS_W-1:0]           packets_reg;
    logic [DROPS_W-1:0]          drops_reg;
    logic [TIME_W-1:0]           last_use_reg;
    logic [PERIOD_W-1:0]         period_eff;
    logic                        commit;
    logic                        hit;
    logic signed [ACTION_W-1:0]  verdict_new;
    logic [DROPS_W-1:0]          drop_add;

    assign period_eff = (sample_period == '0) ? PERIOD_RESET : sample_period;

    // Restoring remainder, DIV_BITS dividend bits per cycle.
    always_comb
    begin
        logic [PERIOD_W:0] trial;
        rem_next = rem_reg;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            trial = {rem_next, dvd_reg[SAMPLE_W-1-i]};
            if (trial >= {1'b0, period_eff})
            begin
                trial = trial - {1'b0, period_eff};
            end
            rem_next = trial[PERIOD_W-1:0];
        end
    end

    assign hit         = cur_reg.sample_en && (rem_reg == '0);
    assign verdict_new = hit ? alt_action : default_action;
    assign drop_add    = (verdict_new == DROP_CODE) ? DROPS_W'(cur_reg.add_packets) : '0;

    always_comb
    begin
        state_next = state_reg;
        fifo_pop   = 1'b0;
        commit     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!fifo_empty)
                begin
                    fifo_pop   = 1'b1;
                    state_next = fifo_data.sample_en ? ST_DIV : ST_DONE;
                end
            end
            ST_DIV:
            begin
                if (cnt_reg == DIV_CNT_W'(DIV_CYCLES - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || pop)
                begin
                    commit     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (fifo_pop)
        begin
            cur_reg <= fifo_data;
            dvd_reg <= fifo_data.sample_val;
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        else if (state_reg == ST_DIV)
        begin
            dvd_reg <= dvd_reg << DIV_BITS;
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (commit)
        begin
            verdict_reg <= verdict_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            bytes_reg     <= '0;
            packets_reg   <= '0;
            drops_reg     <= '0;
            last_use_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
            begin
                out_valid_reg <= 1'b1;
                bytes_reg     <= bytes_reg + cur_reg.add_bytes;
                packets_reg   <= packets_reg + PKTS_W'(cur_reg.add_packets);
                drops_reg     <= drops_reg + drop_add;
                if (!cur_reg.is_update || (cur_reg.use_time > last_use_reg))
                begin
                    last_use_reg <= cur_reg.use_time;
                end
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // The totals change only on commit, which waits for the result slot to
    // drain, so the running totals are also the totals of the waiting result.
    assign empty         = !out_valid_reg;
    assign verdict       = verdict_reg;
    assign total_bytes   = bytes_reg;
    assign total_packets = packets_reg;
    assign total_drops   = drops_reg;
    assign last_use_time = last_use_reg;

endmodule

FILE: src/packet_action_sampler_unit.sv
`timescale 1ns / 1ps

// Packet action unit with random or every-nth sampling and running totals.
// Input items arrive through a queue-style port: an item is taken on a clock
// edge where push is high and full is low. Each item is a packet decision or
// an offload statistics update. Every item yields exactly one result, shown
// on the result ports while empty is low and taken on an edge where pop is
// high and empty is low. Configuration registers are written through the
// cfg_valid/cfg_ready channel, which is always ready; the user must write
// them only while idle, as the block itself does not enforce this.
// A front stage classifies items and steps the every-nth counter, a short
// queue holds them, and a back stage computes the sampling remainder and
// updates the totals. The remainder unit handles four bits per cycle and
// sees only sampled packets. The back stage takes one item at a time and
// pops the next from the queue only after committing the last one's result.
// A result left waiting stalls the back stage; the front keeps taking items
// until the queue is full.
// Reset clears the counter, the totals, the queue and the registers
// (sample_period resets to one).
module packet_action_sampler_unit
    import pas_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic                        opcode,
    input  logic [LEN_W-1:0]            pkt_len,
    input  logic [SAMPLE_W-1:0]         random_value,
    input  logic [TIME_W-1:0]           time_now,
    input  logic [BYTES_W-1:0]          upd_bytes,
    input  logic [UPD_PKTS_W-1:0]       upd_packets,
    input  logic [TIME_W-1:0]           upd_last_use,
    output logic                        empty,
    input  logic                        pop,
    output logic signed [ACTION_W-1:0]  verdict,
    output logic [BYTES_W-1:0]          total_bytes,
    output logic [PKTS_W-1:0]           total_packets,
    output logic [DROPS_W-1:0]          total_drops,
    output logic [TIME_W-1:0]           last_use_time,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data
);

    logic signed [ACTION_W-1:0] default_action_reg;
    logic signed [ACTION_W-1:0] alt_action_reg;
    logic [MODE_W-1:0]          sample_mode_reg;
    logic [PERIOD_W-1:0]        sample_period_reg;
    logic                       accept;
    rec_t                       front_rec;
    rec_t                       fifo_rd;
    logic                       fifo_empty;
    logic                       fifo_pop;

    // The register file takes a write in every cycle; unknown indexes are
    // accepted and ignored.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_action_reg <= '0;
            alt_action_reg     <= '0;
            sample_mode_reg    <= MODE_NONE;
            sample_period_reg  <= PERIOD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_DEFAULT_ACTION: default_action_reg <= cfg_data;
                REG_ALT_ACTION:     alt_action_reg     <= cfg_data;
                REG_SAMPLE_MODE:    sample_mode_reg    <= cfg_data[MODE_W-1:0];
                REG_SAMPLE_PERIOD:  sample_period_reg  <= cfg_data[PERIOD_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign accept = push && !full;

    pas_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .sample_mode  (sample_mode_reg),
        .opcode       (opcode),
        .pkt_len      (pkt_len),
        .random_value (random_value),
        .time_now     (time_now),
        .upd_bytes    (upd_bytes),
        .upd_packets  (upd_packets),
        .upd_last_use (upd_last_use),
        .rec          (front_rec)
    );

    pas_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_data (front_rec),
        .full    (full),
        .rd_en   (fifo_pop),
        .rd_data (fifo_rd),
        .empty   (fifo_empty)
    );

    pas_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .default_action (default_action_reg),
        .alt_action     (alt_action_reg),
        .sample_period  (sample_period_reg),
        .fifo_empty     (fifo_empty),
        .fifo_data      (fifo_rd),
        .fifo_pop       (fifo_pop),
        .pop            (pop),
        .empty          (empty),
        .verdict        (verdict),
        .total_bytes    (total_bytes),
        .total_packets  (total_packets),
        .total_drops    (total_drops),
        .last_use_time  (last_use_time)
    );

endmodule

FILE: dv/packet_action_sampler_unit_test.sv
`timescale 1ns / 1ps

// Self-checking bench for the packet action sampler. A local predictor keeps
// its own copy of the registers, the every-nth counter and the running
// totals, and works out the result of every item when the block accepts it.
// A receiver process pops results, with random stalls, and compares each one
// against the oldest prediction.
module packet_action_sampler_unit_test;
    import pas_pkg::*;

    // Kinds of input item, as carried on the opcode port.
    typedef enum logic {
        OP_PACKET       = 1'b0,
        OP_STATS_UPDATE = 1'b1
    } item_kind_t;

    typedef struct packed {
        item_kind_t            kind;
        logic [LEN_W-1:0]      pkt_len;
        logic [SAMPLE_W-1:0]   random_value;
        logic [TIME_W-1:0]     time_now;
        logic [BYTES_W-1:0]    upd_bytes;
        logic [UPD_PKTS_W-1:0] upd_packets;
        logic [TIME_W-1:0]     upd_last_use;
    } sampler_item_t;

    typedef struct packed {
        logic signed [ACTION_W-1:0] verdict;
        logic [BYTES_W-1:0]         total_bytes;
        logic [PKTS_W-1:0]          total_packets;
        logic [DROPS_W-1:0]         total_drops;
        logic [TIME_W-1:0]          last_use_time;
    } action_result_t;

    // An index that maps to no register; writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 8'd200;

    // The spare mode code, which behaves as no sampling.
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    localparam int HALF_PERIOD   = 4;
    localparam int RESET_CYCLES  = 6;
    // Long enough to cover the slowest sampled item with room to spare.
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 400000;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       push = 1'b0;
    logic                       full;
    logic                       opcode = 1'b0;
    logic [LEN_W-1:0]           pkt_len = '0;
    logic [SAMPLE_W-1:0]        random_value = '0;
    logic [TIME_W-1:0]          time_now = '0;
    logic [BYTES_W-1:0]         upd_bytes = '0;
    logic [UPD_PKTS_W-1:0]      upd_packets = '0;
    logic [TIME_W-1:0]          upd_last_use = '0;
    logic                       empty;
    logic                       pop = 1'b0;
    logic signed [ACTION_W-1:0] verdict;
    logic [BYTES_W-1:0]         total_bytes;
    logic [PKTS_W-1:0]          total_packets;
    logic [DROPS_W-1:0]         total_drops;
    logic [TIME_W-1:0]          last_use_time;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [CFG_DATA_W-1:0]      cfg_data = '0;

    packet_action_sampler_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .opcode        (opcode),
        .pkt_len       (pkt_len),
        .random_value  (random_value),
        .time_now      (time_now),
        .upd_bytes     (upd_bytes),
        .upd_packets   (upd_packets),
        .upd_last_use  (upd_last_use),
        .empty         (empty),
        .pop           (pop),
        .verdict       (verdict),
        .total_bytes   (total_bytes),
        .total_packets (total_packets),
        .total_drops   (total_drops),
        .last_use_time (last_use_time),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // The predictor's copy of the registers, at their reset values.
    logic signed [ACTION_W-1:0] default_action_q = '0;
    logic signed [ACTION_W-1:0] alt_action_q = '0;
    logic [MODE_W-1:0]          sample_mode_q = MODE_NONE;
    logic [PERIOD_W-1:0]        sample_period_q = PERIOD_RESET;

    // The predictor's copy of the block's state.
    logic [SAMPLE_W-1:0] nth_count = '0;
    logic [BYTES_W-1:0]  byte_sum = '0;
    logic [PKTS_W-1:0]   packet_sum = '0;
    logic [DROPS_W-1:0]  drop_sum = '0;
    logic [TIME_W-1:0]   last_stamp = '0;

    // Results predicted for accepted items, oldest first.
    action_result_t pending_results[$];
    int unsigned    failures = 0;

    // Chance in percent that either side starts an idle burst on a cycle.
    int unsigned idle_percent = 0;

    // The pressure test raises the ticket count; the receiver serves each
    // ticket by holding pop low for a long stretch that it counts itself.
    int unsigned hold_tickets = 0;
    int unsigned hold_served = 0;
    int unsigned hold_left = 0;
    int unsigned stall_left = 0;

    initial begin
        forever
        begin
            #HALF_PERIOD clk = ~clk;
        end
    end

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("packet_action_sampler_unit_test NOT OK");
        $finish;
    end

    // A period of zero behaves as a period of one, so every test hits.
    function automatic logic [SAMPLE_W-1:0] sampling_modulus();
        return (sample_period_q == '0) ? 32'd1 : {16'd0, sample_period_q};
    endfunction

    // Applies one item to the predicted state and returns the result the
    // block must produce for it.
    function automatic action_result_t apply_item(input sampler_item_t it);
        action_result_t      r;
        logic [SAMPLE_W-1:0] modulus;
        logic                hit;
        modulus = sampling_modulus();
        hit = 1'b0;
        if (it.kind == OP_PACKET) begin
            // Only the random and every-nth modes sample; the spare mode
            // code leaves the counter alone.
            if (sample_mode_q == MODE_RANDOM) begin
                hit = (it.random_value % modulus) == '0;
            end
            else if (sample_mode_q == MODE_NTH) begin
                nth_count = nth_count + 32'd1;
                hit = (nth_count % modulus) == '0;
            end
            r.verdict = hit ? alt_action_q : default_action_q;
            byte_sum = byte_sum + {48'd0, it.pkt_len};
            packet_sum = packet_sum + 64'd1;
            if (r.verdict == DROP_CODE) begin
                drop_sum = drop_sum + 32'd1;
            end
            last_stamp = it.time_now;
        end
        else begin
            // A statistics update never samples and reports the default
            // action; its drops count only when that action is a drop.
            r.verdict = default_action_q;
            byte_sum = byte_sum + it.upd_bytes;
            packet_sum = packet_sum + {32'd0, it.upd_packets};
            if (default_action_q == DROP_CODE) begin
                drop_sum = drop_sum + it.upd_packets;
            end
            if (it.upd_last_use > last_stamp) begin
                last_stamp = it.upd_last_use;
            end
        end
        r.total_bytes = byte_sum;
        r.total_packets = packet_sum;
        r.total_drops = drop_sum;
        r.last_use_time = last_stamp;
        return r;
    endfunction

    // Offers one item and returns at the edge where the block takes it.
    // Push is left high so that the next item can follow without a gap.
    task automatic send_item(input sampler_item_t it);
        push <= 1'b1;
        opcode <= it.kind;
        pkt_len <= it.pkt_len;
        random_value <= it.random_value;
        time_now <= it.time_now;
        upd_bytes <= it.upd_bytes;
        upd_packets <= it.upd_packets;
        upd_last_use <= it.upd_last_use;
        @(posedge clk);
        while (full) @(posedge clk);
        pending_results.push_back(apply_item(it));
    endtask

    task automatic sender_gap(input int unsigned cycles);
        push <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Waits until every predicted result has been checked and the back stage
    // has had time to go quiet, so that registers can be rewritten safely.
    task automatic wait_until_drained();
        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Leaves cfg_valid high; the caller lowers it after its last write.
    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (index)
            REG_DEFAULT_ACTION: default_action_q = data;
            REG_ALT_ACTION:     alt_action_q = data;
            REG_SAMPLE_MODE:    sample_mode_q = data[MODE_W-1:0];
            REG_SAMPLE_PERIOD:  sample_period_q = data[PERIOD_W-1:0];
            default: ;
        endcase
    endtask

    // Rewrites all four registers once the block is idle. Bits above the
    // mode and period fields carry noise, which the block must ignore.
    task automatic program_sampler(input logic signed [ACTION_W-1:0] dflt,
                                   input logic signed [ACTION_W-1:0] alt,
                                   input logic [MODE_W-1:0] mode,
                                   input logic [PERIOD_W-1:0] period);
        logic [CFG_DATA_W-1:0] noise;
        noise = $urandom;
        wait_until_drained();
        write_register(REG_DEFAULT_ACTION, dflt);
        write_register(REG_ALT_ACTION, alt);
        write_register(REG_SAMPLE_MODE, {noise[CFG_DATA_W-1:MODE_W], mode});
        write_register(REG_SAMPLE_PERIOD, {noise[CFG_DATA_W-1:PERIOD_W], period});
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [63:0] random_word64();
        return {$urandom, $urandom};
    endfunction

    // Directed items; the fields that the item kind ignores carry noise.
    function automatic sampler_item_t packet_item(input logic [LEN_W-1:0] len,
                                                  input logic [SAMPLE_W-1:0] rnd,
                                                  input logic [TIME_W-1:0] stamp);
        sampler_item_t it;
        it.kind = OP_PACKET;
        it.pkt_len = len;
        it.random_value = rnd;
        it.time_now = stamp;
        it.upd_bytes = random_word64();
        it.upd_packets = $urandom;
        it.upd_last_use = random_word64();
        return it;
    endfunction

    function automatic sampler_item_t update_item(input logic [BYTES_W-1:0] bytes,
                                                  input logic [UPD_PKTS_W-1:0] pkts,
                                                  input logic [TIME_W-1:0] stamp);
        sampler_item_t it;
        it.kind = OP_STATS_UPDATE;
        it.pkt_len = LEN_W'($urandom);
        it.random_value = $urandom;
        it.time_now = random_word64();
        it.upd_bytes = bytes;
        it.upd_packets = pkts;
        it.upd_last_use = stamp;
        return it;
    endfunction

    // Random item, mostly packets. A third of the random words are exact
    // multiples of the period so that random sampling hits often enough.
    function automatic sampler_item_t random_item();
        sampler_item_t it;
        it.kind = ($urandom_range(0, 99) < 70) ? OP_PACKET : OP_STATS_UPDATE;
        case ($urandom_range(0, 9))
            0:       it.pkt_len = '0;
            1:       it.pkt_len = '1;
            default: it.pkt_len = LEN_W'($urandom);
        endcase
        if ($urandom_range(0, 2) == 0) begin
            it.random_value = sampling_modulus() * $urandom_range(0, 65535);
        end
        else begin
            it.random_value = $urandom;
        end
        it.time_now = random_word64();
        it.upd_bytes = ($urandom_range(0, 7) == 0)
                       ? 64'hFFFF_FFFF_FFFF_0000 | {32'd0, $urandom}
                       : random_word64();
        it.upd_packets = $urandom;
        case ($urandom_range(0, 9))
            0:       it.upd_last_use = '0;
            1:       it.upd_last_use = '1;
            2:       it.upd_last_use = last_stamp;
            default: it.upd_last_use = random_word64();
        endcase
        return it;
    endfunction

    function automatic logic signed [ACTION_W-1:0] random_action();
        case ($urandom_range(0, 4))
            0:       return DROP_CODE;
            1:       return 32'sh8000_0000;
            2:       return 32'sh7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [PERIOD_W-1:0] random_period();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return PERIOD_W'($urandom_range(1, 8));
            default: return PERIOD_W'($urandom_range(1, 300));
        endcase
    endfunction

    // Compares the result on the ports with the oldest prediction.
    task automatic check_result();
        action_result_t want;
        if (pending_results.size() == 0) begin
            $error("result popped with no item outstanding");
            failures++;
        end
        else begin
            want = pending_results.pop_front();
            if (verdict !== want.verdict) begin
                $error("verdict: expected %0d, got %0d", want.verdict, verdict);
                failures++;
            end
            if (total_bytes !== want.total_bytes) begin
                $error("total_bytes: expected %0h, got %0h", want.total_bytes, total_bytes);
                failures++;
            end
            if (total_packets !== want.total_packets) begin
                $error("total_packets: expected %0h, got %0h",
                       want.total_packets, total_packets);
                failures++;
            end
            if (total_drops !== want.total_drops) begin
                $error("total_drops: expected %0h, got %0h", want.total_drops, total_drops);
                failures++;
            end
            if (last_use_time !== want.last_use_time) begin
                $error("last_use_time: expected %0h, got %0h",
                       want.last_use_time, last_use_time);
                failures++;
            end
        end
    endtask

    // Receiver: checks the item taken at this edge, then decides whether to
    // pop on the next one. A pending hold ticket wins over random stalls.
    always @(posedge clk) begin
        if (rst_n) begin
            if (pop && !empty) begin
                check_result();
            end
            if (hold_left != 0) begin
                hold_left--;
                pop <= 1'b0;
            end
            else if (hold_served != hold_tickets) begin
                hold_served++;
                hold_left = HOLD_CYCLES - 1;
                pop <= 1'b0;
            end
            else if (stall_left != 0) begin
                stall_left--;
                pop <= 1'b0;
            end
            else if (idle_percent != 0 && $urandom_range(0, 99) < idle_percent) begin
                stall_left = $urandom_range(1, 13) - 1;
                pop <= 1'b0;
            end
            else begin
                pop <= 1'b1;
            end
        end
    end

    // Reset values: no sampling, both actions zero. Covers the length
    // extremes, wrapping of the byte total, and an update whose last-use time
    // is older than the stored one (the stored one is kept).
    task automatic test_reset_defaults();
        send_item(packet_item('0, $urandom, 64'd1));
        send_item(packet_item('1, $urandom, '1));
        send_item(update_item('1, '1, '0));
        send_item(update_item('1, 32'd7, 64'h8000_0000_0000_0000));
    endtask

    // Drop accounting: with drop as the default action every packet counts a
    // drop, and updates add their packet count, so the 32-bit total wraps.
    task automatic test_drop_accounting();
        program_sampler(DROP_CODE, 32'sd9, MODE_NONE, 16'd1);
        send_item(packet_item(16'd64, $urandom, 64'd100));
        send_item(update_item(64'd1000, '1, 64'd50));
        send_item(update_item(64'd10, 32'd5, 64'd200));
    endtask

    // Random sampling with the action extremes, the largest period, and a
    // period of zero.
    task automatic test_random_sampling();
        program_sampler(32'sh8000_0000, 32'sh7FFF_FFFF, MODE_RANDOM, 16'd4);
        send_item(packet_item(16'd60, 32'd0, 64'd10));
        send_item(packet_item(16'd60, 32'd3, 64'd11));
        send_item(packet_item(16'd60, 32'd8, 64'd12));
        send_item(packet_item(16'd60, '1, 64'd13));
        program_sampler(32'sh7FFF_FFFF, DROP_CODE, MODE_RANDOM, '1);
        send_item(packet_item(16'd1500, 32'd131070, 64'd14));
        send_item(packet_item(16'd1500, 32'd1, 64'd15));
        program_sampler(32'sd3, DROP_CODE, MODE_RANDOM, '0);
        send_item(packet_item(16'd1500, 32'd12345, 64'd16));
    endtask

    // Every-nth sampling: updates do not step the counter, the spare mode
    // code holds it, it carries on when the mode returns, and a period of
    // zero hits on every packet. The last packet follows a write to an unmapped index.
    task automatic test_every_nth();
        program_sampler(32'sd5, DROP_CODE, MODE_NTH, 16'd3);
        send_item(packet_item(16'd100, $urandom, 64'd20));
        send_item(update_item(64'd5, 32'd2, 64'd30));
        send_item(packet_item(16'd100, $urandom, 64'd21));
        send_item(packet_item(16'd100, $urandom, 64'd22));
        send_item(packet_item(16'd100, $urandom, 64'd23));
        program_sampler(32'sd5, DROP_CODE, MODE_SPARE, 16'd3);
        send_item(packet_item(16'd100, $urandom, 64'd24));
        program_sampler(32'sd5, DROP_CODE, MODE_NTH, '0);
        send_item(packet_item(16'd100, $urandom, 64'd25));
        wait_until_drained();
        write_register(REG_UNMAPPED, $urandom);
        cfg_valid <= 1'b0;
        send_item(packet_item(16'd100, $urandom, 64'd26));
    endtask

    // Phases of random traffic, each under a fresh random configuration and
    // its own idling rate; one phase runs with no idling at all.
    task automatic test_random_traffic();
        int unsigned phase;
        int unsigned n;
        for (phase = 0; phase < 6; phase++) begin
            program_sampler(random_action(), random_action(),
                            MODE_W'($urandom_range(0, 3)), random_period());
            idle_percent = (phase == 3) ? 0 : $urandom_range(5, 40);
            for (n = 0; n < 150; n++) begin
                if (idle_percent != 0 && $urandom_range(0, 99) < idle_percent) begin
                    sender_gap($urandom_range(1, 13));
                end
                send_item(random_item());
            end
        end
    endtask

    // Backpressure: the receiver holds off for a long stretch while items
    // keep coming back to back, so the block fills up and raises full.
    task automatic test_backpressure();
        int unsigned n;
        program_sampler(DROP_CODE, 32'sd1, MODE_NTH, 16'd2);
        idle_percent = 0;
        hold_tickets <= hold_tickets + 1;
        for (n = 0; n < 24; n++) begin
            send_item(random_item());
        end
    endtask

    // The last stretch: random items at full rate on both sides.
    task automatic test_full_rate_tail();
        int unsigned n;
        program_sampler(random_action(), DROP_CODE, MODE_RANDOM, 16'd3);
        idle_percent = 0;
        for (n = 0; n < 100; n++) begin
            send_item(random_item());
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_drop_accounting();
        test_random_sampling();
        test_every_nth();
        test_random_traffic();
        test_backpressure();
        test_full_rate_tail();
        wait_until_drained();
        if (failures == 0 && pending_results.size() == 0) begin
            $display("packet_action_sampler_unit_test OK");
        end
        else begin
            $display("packet_action_sampler_unit_test NOT OK");
        end
        $finish;
    end

endmodule

FILE: sim.f
src/pas_pkg.sv
src/pas_front.sv
src/pas_fifo.sv
src/pas_back.sv
src/packet_action_sampler_unit.sv
dv/packet_action_sampler_unit_test.sv
